/* design/lruipv_pkg.sv */
`default_nettype none

package lruipv_pkg;

   // Ways per set and the width of one recency position (0..16)
   localparam int NUM_WAYS  = 16;
   localparam int POS_W     = 5;
   localparam int SET_IDX_W = 6;
   localparam int WAY_W     = 4;
   localparam int VEC_LOW_W  = 60;
   localparam int VEC_HIGH_W = 25;
   localparam int VEC_W      = VEC_LOW_W + VEC_HIGH_W;

   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [WAY_W-1:0]     way_type;
   typedef logic [SET_IDX_W-1:0] set_idx_type;
   typedef logic [NUM_WAYS-1:0][POS_W-1:0] row_type;

   typedef enum logic [1:0] {
      CMD_HIT    = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_INVAL  = 2'd2,
      CMD_VICTIM = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_VEC_LOW  = 1'b0,
      CSR_VEC_HIGH = 1'b1
   } csr_idx_type;

   // Position codes
   localparam pos_type EMPTY_POS = 5'd16;
   localparam pos_type LRU_POS   = 5'd15;
   localparam pos_type INSERT_K  = 5'd16;

   // Promotion vector after reset: 0,0,1,0,3,0,1,2,1,0,5,1,0,0,1,11,13
   localparam logic [VEC_LOW_W-1:0]  VEC_LOW_RESET  = 60'd41659465861170176;
   localparam logic [VEC_HIGH_W-1:0] VEC_HIGH_RESET = 25'd13992960;

   // Set contents after reset: ways 0..12 empty, ways 13,14,15 at 15,14,13
   localparam row_type RESET_ROW = {5'd13, 5'd14, 5'd15, {13{5'd16}}};

endpackage

`default_nettype wire

/* design/lruipv_if.sv */
`default_nettype none

// Command channel
interface lruipv_req_if;
   logic                     valid;
   logic                     ready;
   lruipv_pkg::cmd_type      cmd;
   lruipv_pkg::set_idx_type  set_index;
   lruipv_pkg::way_type      way;

   modport source (output valid, output cmd, output set_index, output way, input ready);
   modport sink   (input valid, input cmd, input set_index, input way, output ready);
endinterface

// Result channel
interface lruipv_rsp_if;
   logic                 valid;
   logic                 ready;
   lruipv_pkg::way_type  victim_way;
   logic                 victim_was_empty;

   modport source (output valid, output victim_way, output victim_was_empty, input ready);
   modport sink   (input valid, input victim_way, input victim_was_empty, output ready);
endinterface

// Register write channel
interface lruipv_csr_if;
   logic                                  valid;
   logic                                  ready;
   lruipv_pkg::csr_idx_type               index;
   logic [lruipv_pkg::VEC_LOW_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/lru_ipv_replacement.sv */
// LRU replacement state with a programmable insertion/promotion vector for a
// 16-way cache. Each set stores one 80-bit row (a 5-bit recency position per
// way, 16 = empty) in a single-port-write, registered-read memory of N_SETS
// rows. One command is taken every cycle unless the result channel stalls:
// the row is read when the beat is accepted, then updated and written back
// as the result moves into the output register. A command to the same set as
// a hit, fill or invalidate just before it takes the row from a bypass
// register. After reset a clearing pass writes the reset contents to every
// set, one per cycle; commands are held off during it while register writes
// are taken. Out-of-range set indexes are ignored and return zero.
`default_nettype none

module lru_ipv_replacement #(
   parameter int N_SETS = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   lruipv_req_if.sink         req_chan,
   lruipv_rsp_if.source       rsp_chan,
   lruipv_csr_if.sink         csr_chan
);

   localparam int SET_AW = (N_SETS > 1) ? $clog2(N_SETS) : 1;

   // Storage and pipeline registers
   lruipv_pkg::row_type                          mem [N_SETS];
   lruipv_pkg::row_type                          rd_ff;
   lruipv_pkg::row_type                          wb_row_ff;
   logic                                         fwd_ff;
   logic                                         s1_valid_ff;
   lruipv_pkg::cmd_type                          s1_cmd_ff;
   lruipv_pkg::set_idx_type                      s1_set_ff;
   lruipv_pkg::way_type                          s1_way_ff;
   logic                                         rsp_valid_ff;
   lruipv_pkg::way_type                          rsp_way_ff;
   logic                                         rsp_empty_ff;
   logic [lruipv_pkg::VEC_LOW_W-1:0]             vec_low_ff;
   logic [lruipv_pkg::VEC_HIGH_W-1:0]            vec_high_ff;
   logic                                         clr_active_ff;
   logic [SET_AW-1:0]                            clr_addr_ff;

   // Combinational signals
   logic                                         req_fire;
   logic                                         s1_fire;
   logic                                         s1_inrange;
   logic                                         s1_we;
   logic [lruipv_pkg::VEC_W-1:0]                 vec_all;
   lruipv_pkg::row_type                          cur_row;
   lruipv_pkg::pos_type                          from_pos;
   lruipv_pkg::pos_type                          hit_k;
   lruipv_pkg::pos_type                          to_pos;
   lruipv_pkg::row_type                          new_row_in;
   lruipv_pkg::way_type                          rsp_way_in;
   logic                                         rsp_empty_in;
   logic                                         mem_we;
   logic [SET_AW-1:0]                            mem_waddr;
   lruipv_pkg::row_type                          mem_wdata;
   lruipv_pkg::pos_type                          l1_pos [8];
   lruipv_pkg::way_type                          l1_idx [8];
   lruipv_pkg::pos_type                          l2_pos [4];
   lruipv_pkg::way_type                          l2_idx [4];
   lruipv_pkg::pos_type                          l3_pos [2];
   lruipv_pkg::way_type                          l3_idx [2];
   lruipv_pkg::pos_type                          best_pos;
   lruipv_pkg::way_type                          best_idx;

   // Vector entry k (0..16), clamped to the LRU position
   function automatic lruipv_pkg::pos_type vec_entry(
      input logic [lruipv_pkg::VEC_W-1:0] vec,
      input lruipv_pkg::pos_type          k
   );
      lruipv_pkg::pos_type raw;
      raw = vec[k * lruipv_pkg::POS_W +: lruipv_pkg::POS_W];
      return (raw > lruipv_pkg::LRU_POS) ? lruipv_pkg::LRU_POS : raw;
   endfunction

   // Handshakes
   assign s1_fire         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready  = !clr_active_ff && (!s1_valid_ff || s1_fire);
   assign req_fire        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.victim_way       = rsp_way_ff;
   assign rsp_chan.victim_was_empty = rsp_empty_ff;

   assign s1_inrange = (32'(s1_set_ff) < N_SETS);
   assign s1_we      = s1_fire && s1_inrange && (s1_cmd_ff != lruipv_pkg::CMD_VICTIM);
   assign vec_all    = {vec_high_ff, vec_low_ff};

   // Pick the row: bypass the write that happened as this beat was read
   assign cur_row  = fwd_ff ? wb_row_ff : rd_ff;
   assign from_pos = cur_row[s1_way_ff];
   assign hit_k    = (from_pos > lruipv_pkg::EMPTY_POS) ? lruipv_pkg::EMPTY_POS : from_pos;

   // Target position of the way acted on
   always_comb begin
      unique case (s1_cmd_ff)
         lruipv_pkg::CMD_HIT:    to_pos = vec_entry(vec_all, hit_k);
         lruipv_pkg::CMD_FILL:   to_pos = vec_entry(vec_all, lruipv_pkg::INSERT_K);
         lruipv_pkg::CMD_INVAL:  to_pos = lruipv_pkg::EMPTY_POS;
         lruipv_pkg::CMD_VICTIM: to_pos = from_pos;
         default:                to_pos = from_pos;
      endcase
   end

   // Move the way and shift the ways lying between old and new position
   always_comb begin
      for (int i = 0; i < lruipv_pkg::NUM_WAYS; i++) begin
         if (lruipv_pkg::way_type'(i) == s1_way_ff) begin
            new_row_in[i] = to_pos;
         end else if (to_pos < from_pos && cur_row[i] >= to_pos && cur_row[i] < from_pos) begin
            new_row_in[i] = cur_row[i] + 5'd1;
         end else if (to_pos > from_pos && cur_row[i] > from_pos && cur_row[i] <= to_pos
                      && cur_row[i] < lruipv_pkg::EMPTY_POS) begin
            new_row_in[i] = cur_row[i] - 5'd1;
         end else begin
            new_row_in[i] = cur_row[i];
         end
      end
   end

   // Victim: greatest position, ties to the higher way, as a four-level tree
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         if (cur_row[2*j+1] >= cur_row[2*j]) begin
            l1_pos[j] = cur_row[2*j+1];
            l1_idx[j] = lruipv_pkg::way_type'(2*j+1);
         end else begin
            l1_pos[j] = cur_row[2*j];
            l1_idx[j] = lruipv_pkg::way_type'(2*j);
         end
      end
      for (int j = 0; j < 4; j++) begin
         if (l1_pos[2*j+1] >= l1_pos[2*j]) begin
            l2_pos[j] = l1_pos[2*j+1];
            l2_idx[j] = l1_idx[2*j+1];
         end else begin
            l2_pos[j] = l1_pos[2*j];
            l2_idx[j] = l1_idx[2*j];
         end
      end
      for (int j = 0; j < 2; j++) begin
         if (l2_pos[2*j+1] >= l2_pos[2*j]) begin
            l3_pos[j] = l2_pos[2*j+1];
            l3_idx[j] = l2_idx[2*j+1];
         end else begin
            l3_pos[j] = l2_pos[2*j];
            l3_idx[j] = l2_idx[2*j];
         end
      end
      if (l3_pos[1] >= l3_pos[0]) begin
         best_pos = l3_pos[1];
         best_idx = l3_idx[1];
      end else begin
         best_pos = l3_pos[0];
         best_idx = l3_idx[0];
      end
   end

   // Result of this beat
   always_comb begin
      if (s1_inrange && s1_cmd_ff == lruipv_pkg::CMD_VICTIM) begin
         rsp_way_in   = best_idx;
         rsp_empty_in = (best_pos >= lruipv_pkg::EMPTY_POS);
      end else begin
         rsp_way_in   = '0;
         rsp_empty_in = 1'b0;
      end
   end

   // Memory write port: clearing pass or writeback
   always_comb begin
      if (clr_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = lruipv_pkg::RESET_ROW;
      end else begin
         mem_we    = s1_we;
         mem_waddr = SET_AW'(s1_set_ff);
         mem_wdata = new_row_in;
      end
   end

   // Row memory, read at accept
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_ff <= mem[SET_AW'(req_chan.set_index)];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff <= req_chan.cmd;
         s1_set_ff <= req_chan.set_index;
         s1_way_ff <= req_chan.way;
      end
      if (s1_we) begin
         wb_row_ff <= new_row_in;
      end
      if (s1_fire) begin
         rsp_way_ff   <= rsp_way_in;
         rsp_empty_ff <= rsp_empty_in;
      end
   end

   // Control state, clearing pass and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         vec_low_ff    <= lruipv_pkg::VEC_LOW_RESET;
         vec_high_ff   <= lruipv_pkg::VEC_HIGH_RESET;
      end else begin
         // advance the clearing pass
         if (clr_active_ff) begin
            if (clr_addr_ff == SET_AW'(N_SETS - 1)) begin
               clr_active_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         // update stage and bypass flag
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= s1_we && (s1_set_ff == req_chan.set_index);
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
            fwd_ff      <= 1'b0;
         end
         // output register
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // register writes
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               lruipv_pkg::CSR_VEC_LOW:  vec_low_ff  <= csr_chan.data;
               lruipv_pkg::CSR_VEC_HIGH: vec_high_ff <= csr_chan.data[lruipv_pkg::VEC_HIGH_W-1:0];
               default:                  vec_low_ff  <= vec_low_ff;
            endcase
         end
      end
   end

   // No command is taken while the clearing pass runs
   a_clr_blocks: assert property (@(posedge clock)
      clr_active_ff |-> !req_chan.ready)
      else $error("command taken during clearing pass");

   // Reset always starts a clearing pass
   a_reset_clr: assert property (@(posedge clock)
      reset |=> clr_active_ff)
      else $error("clearing pass not started by reset");

   // The bypass only ever refers to a beat in the update stage
   a_fwd_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("bypass flag without a beat in the update stage");

   // An out-of-range set returns a zero result
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_inrange) |=> (rsp_way_ff == '0 && !rsp_empty_ff))
      else $error("out-of-range set gave a nonzero result");

endmodule

`default_nettype wire

/* test/tb_lru_ipv_replacement.sv */
`timescale 1ns / 100ps

module tb_lru_ipv_replacement;

   localparam int SET_COUNT      = 64;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLDOFF_AT     = 180;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int PHASE_BEATS    = 125;
   localparam int PHASE_COUNT    = 6;
   localparam int REPORT_LIMIT   = 100;

   typedef struct packed {
      lruipv_pkg::cmd_type     cmd;
      lruipv_pkg::set_idx_type set_index;
      lruipv_pkg::way_type     way;
   } cmd_beat_type;

   typedef struct packed {
      lruipv_pkg::way_type victim_way;
      logic                victim_was_empty;
   } victim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lruipv_req_if req_bus();
   lruipv_rsp_if rsp_bus();
   lruipv_csr_if csr_bus();

   lru_ipv_replacement #(.N_SETS(SET_COUNT)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   // Shadow copy of the recency state and the promotion vector
   lruipv_pkg::pos_type                recency [SET_COUNT][lruipv_pkg::NUM_WAYS];
   logic [lruipv_pkg::VEC_LOW_W-1:0]   vec_low_q;
   logic [lruipv_pkg::VEC_HIGH_W-1:0]  vec_high_q;

   cmd_beat_type            pending_cmds[$];
   victim_type              expected_victims[$];
   int unsigned             accepted_count = 0;
   int unsigned             mismatch_count = 0;
   lruipv_pkg::set_idx_type hot_sets [4];

   task automatic report_mismatch(string what);
      if (mismatch_count < REPORT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Look up vector entry k, clamped to the LRU position
   function automatic lruipv_pkg::pos_type promote_target(int unsigned k);
      logic [4:0] raw;
      if (k < 12)
         raw = vec_low_q[5*k +: 5];
      else
         raw = vec_high_q[5*(k-12) +: 5];
      return (raw > lruipv_pkg::LRU_POS) ? lruipv_pkg::LRU_POS : raw;
   endfunction

   // Move one way to a new position and shift the ways in between by one
   function automatic void relocate_way(int s, int w, lruipv_pkg::pos_type to);
      lruipv_pkg::pos_type from;
      lruipv_pkg::pos_type p;
      from = recency[s][w];
      for (int i = 0; i < lruipv_pkg::NUM_WAYS; i++) begin
         if (i != w) begin
            p = recency[s][i];
            if (to < from && p >= to && p < from)
               p = p + 1'b1;
            else if (to > from && p > from && p <= to && p < lruipv_pkg::EMPTY_POS)
               p = p - 1'b1;
            recency[s][i] = p;
         end
      end
      recency[s][w] = to;
   endfunction

   // Apply one command to the shadow state and return the victim it reports
   function automatic victim_type apply_command(cmd_beat_type b);
      victim_type          r;
      lruipv_pkg::pos_type p;
      lruipv_pkg::pos_type best_pos;
      lruipv_pkg::way_type best;
      int                  s;
      r = '0;
      s = b.set_index;
      case (b.cmd)
         lruipv_pkg::CMD_HIT: begin
            p = recency[s][b.way];
            relocate_way(s, b.way,
                         promote_target(p > lruipv_pkg::EMPTY_POS ? lruipv_pkg::EMPTY_POS : p));
         end
         lruipv_pkg::CMD_FILL:  relocate_way(s, b.way, promote_target(lruipv_pkg::INSERT_K));
         lruipv_pkg::CMD_INVAL: relocate_way(s, b.way, lruipv_pkg::EMPTY_POS);
         lruipv_pkg::CMD_VICTIM: begin
            best = '0;
            best_pos = '0;
            // ties go to the highest-numbered way
            for (int i = 0; i < lruipv_pkg::NUM_WAYS; i++) begin
               if (recency[s][i] >= best_pos) begin
                  best_pos = recency[s][i];
                  best = lruipv_pkg::way_type'(i);
               end
            end
            r.victim_way = best;
            r.victim_was_empty = (best_pos >= lruipv_pkg::EMPTY_POS);
         end
      endcase
      return r;
   endfunction

   function automatic void queue_cmd(lruipv_pkg::cmd_type c, int s, int w);
      cmd_beat_type b;
      b.cmd = c;
      b.set_index = lruipv_pkg::set_idx_type'(s);
      b.way = lruipv_pkg::way_type'(w);
      pending_cmds = {pending_cmds, b};
   endfunction

   // Queue random commands, mostly on a few hot sets so sets fill up
   function automatic void queue_random(int count);
      int                  pick;
      lruipv_pkg::cmd_type c;
      int                  s;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40)
            c = lruipv_pkg::CMD_HIT;
         else if (pick < 70)
            c = lruipv_pkg::CMD_FILL;
         else if (pick < 80)
            c = lruipv_pkg::CMD_INVAL;
         else
            c = lruipv_pkg::CMD_VICTIM;
         if ($urandom_range(99) < 85)
            s = hot_sets[$urandom_range(3)];
         else
            s = $urandom_range(SET_COUNT-1);
         queue_cmd(c, s, $urandom_range(lruipv_pkg::NUM_WAYS-1));
      end
   endfunction

   function automatic logic [lruipv_pkg::VEC_LOW_W-1:0] rand_vec();
      logic [63:0] r64;
      r64 = {$urandom, $urandom};
      return r64[lruipv_pkg::VEC_LOW_W-1:0];
   endfunction

   // Write one register and track it once the beat is taken
   task automatic write_csr(lruipv_pkg::csr_idx_type idx,
                            logic [lruipv_pkg::VEC_LOW_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == lruipv_pkg::CSR_VEC_LOW)
         vec_low_q = value;
      else
         vec_high_q = value[lruipv_pkg::VEC_HIGH_W-1:0];
   endtask

   task automatic write_vector(logic [lruipv_pkg::VEC_LOW_W-1:0] low,
                               logic [lruipv_pkg::VEC_LOW_W-1:0] high);
      if ($urandom_range(1)) begin
         write_csr(lruipv_pkg::CSR_VEC_LOW, low);
         write_csr(lruipv_pkg::CSR_VEC_HIGH, high);
      end else begin
         write_csr(lruipv_pkg::CSR_VEC_HIGH, high);
         write_csr(lruipv_pkg::CSR_VEC_LOW, low);
      end
   endtask

   // Wait until every queued command is taken and every result is back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || expected_victims.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Command driver: bursts of random length with random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      cmd_beat_type taken;
      cmd_beat_type next_beat;
      victim_type   result_next;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken.cmd = req_bus.cmd;
            taken.set_index = req_bus.set_index;
            taken.way = req_bus.way;
            result_next = apply_command(taken);
            expected_victims = {expected_victims, result_next};
            accepted_count++;
         end
         // hold the beat until it is taken, then offer the next one or idle
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               next_beat = pending_cmds.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.cmd       <= next_beat.cmd;
               req_bus.set_index <= next_beat.set_index;
               req_bus.way       <= next_beat.way;
               if (burst_left != 0) begin
                  burst_left--;
               end else if ($urandom_range(4) == 0) begin
                  burst_left = 64;
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, once, after enough commands have gone in
   int unsigned holdoff_left = 0;
   logic        holdoff_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
         holdoff_done <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && accepted_count >= HOLDOFF_AT) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end
   end

   // Result receiver: stall on a 16-bit ready pattern, redrawn after each pass
   logic [15:0] ready_pattern = 16'hFFFF;
   int unsigned pattern_bit = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (holdoff_left == 0) && ready_pattern[pattern_bit];
         if (pattern_bit == 15) begin
            pattern_bit <= 0;
            case ($urandom_range(3))
               0: ready_pattern <= 16'hFFFF;
               1: ready_pattern <= 16'($urandom | $urandom);
               2: ready_pattern <= 16'($urandom);
               default: ready_pattern <= 16'($urandom & $urandom);
            endcase
         end else begin
            pattern_bit <= pattern_bit + 1;
         end
      end
   end

   // Result monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin
      victim_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_victims.size() == 0) begin
            report_mismatch($sformatf("unexpected result: victim_way %0d victim_was_empty %0b",
                                      rsp_bus.victim_way, rsp_bus.victim_was_empty));
         end else begin
            want = expected_victims.pop_front();
            if (rsp_bus.victim_way !== want.victim_way)
               report_mismatch($sformatf("victim_way %0d, want %0d",
                                         rsp_bus.victim_way, want.victim_way));
            if (rsp_bus.victim_was_empty !== want.victim_was_empty)
               report_mismatch($sformatf("victim_was_empty %0b, want %0b",
                                         rsp_bus.victim_was_empty, want.victim_was_empty));
         end
      end
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      // drive every input and load the shadow state with its reset contents
      req_bus.valid     = 1'b0;
      req_bus.cmd       = lruipv_pkg::CMD_HIT;
      req_bus.set_index = '0;
      req_bus.way       = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = lruipv_pkg::CSR_VEC_LOW;
      csr_bus.data      = '0;
      vec_low_q  = lruipv_pkg::VEC_LOW_RESET;
      vec_high_q = lruipv_pkg::VEC_HIGH_RESET;
      for (int s = 0; s < SET_COUNT; s++)
         for (int w = 0; w < lruipv_pkg::NUM_WAYS; w++)
            recency[s][w] = (w >= 13) ? lruipv_pkg::pos_type'(28 - w) : lruipv_pkg::EMPTY_POS;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset vector: empty ties, same-position moves, hit on an empty way
      queue_cmd(lruipv_pkg::CMD_VICTIM, 0, 0);
      queue_cmd(lruipv_pkg::CMD_FILL,   0, 15);
      queue_cmd(lruipv_pkg::CMD_HIT,    0, 0);
      queue_cmd(lruipv_pkg::CMD_VICTIM, 0, 7);
      queue_cmd(lruipv_pkg::CMD_HIT,    0, 0);
      queue_cmd(lruipv_pkg::CMD_HIT,    0, 0);
      queue_cmd(lruipv_pkg::CMD_HIT,    0, 14);
      queue_cmd(lruipv_pkg::CMD_INVAL,  0, 14);
      queue_cmd(lruipv_pkg::CMD_VICTIM, 0, 15);
      queue_cmd(lruipv_pkg::CMD_HIT,    63, 15);
      queue_cmd(lruipv_pkg::CMD_HIT,    63, 15);
      queue_cmd(lruipv_pkg::CMD_FILL,   63, 0);
      queue_cmd(lruipv_pkg::CMD_INVAL,  63, 15);
      queue_cmd(lruipv_pkg::CMD_INVAL,  63, 1);
      queue_cmd(lruipv_pkg::CMD_VICTIM, 63, 0);
      queue_cmd(lruipv_pkg::CMD_VICTIM, 42, 10);
      queue_cmd(lruipv_pkg::CMD_FILL,   21, 5);
      queue_cmd(lruipv_pkg::CMD_VICTIM, 21, 5);
      wait_idle();

      // all entries above 15: clamp, moves toward LRU leave empty ways alone
      write_vector('1, '1);
      queue_cmd(lruipv_pkg::CMD_HIT,    1, 15);
      queue_cmd(lruipv_pkg::CMD_FILL,   1, 2);
      queue_cmd(lruipv_pkg::CMD_HIT,    1, 3);
      queue_cmd(lruipv_pkg::CMD_VICTIM, 1, 0);
      queue_cmd(lruipv_pkg::CMD_HIT,    1, 13);
      queue_cmd(lruipv_pkg::CMD_VICTIM, 1, 0);
      wait_idle();

      // random phases, each under its own vector
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: write_vector(rand_vec(), rand_vec());
            1: write_vector('0, '0);
            2: write_vector(lruipv_pkg::VEC_LOW_RESET,
                            lruipv_pkg::VEC_LOW_W'(lruipv_pkg::VEC_HIGH_RESET));
            3: write_vector('1, rand_vec());
            default: write_vector(rand_vec(), rand_vec());
         endcase
         for (int h = 0; h < 4; h++)
            hot_sets[h] = lruipv_pkg::set_idx_type'($urandom_range(SET_COUNT-1));
         if (phase == 2) begin
            // pause the sender mid-phase until every result is back
            queue_random(PHASE_BEATS / 2);
            wait_idle();
            queue_random(PHASE_BEATS - PHASE_BEATS / 2);
         end else begin
            queue_random(PHASE_BEATS);
         end
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* lru_ipv_replacement.f */
design/lruipv_pkg.sv
design/lruipv_if.sv
design/lru_ipv_replacement.sv
test/tb_lru_ipv_replacement.sv
